FILE: rtl/core/mie_pkg.sv
// Shared types and constants for the modular inverse unit.
// Used by mie_ctrl, mie_dpath and the top level; depends on nothing.
package mie_pkg;

	// operand width and the width of coefficient magnitudes and quotient products
	localparam int WIDTH      = 31;
	localparam int DW         = WIDTH + 2;
	localparam int STEP_LIMIT = 2 * WIDTH + 4;
	localparam int STEP_W     = $clog2(STEP_LIMIT + 1);
	localparam int DCNT_W     = $clog2(DW);

	// controller to datapath commands
	typedef struct packed {
		logic load;      // capture a new word from the input ports
		logic div_init;  // set up the shared divider
		logic reduce;    // with div_init: divide the coefficient by the modulus
		logic div_step;  // one restoring division bit
		logic update;    // commit one Euclid step
		logic finish;    // register the result
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic cur_zero;
		logic mod_zero;
	} dp_stat_t;

endpackage

FILE: rtl/core/mie_dpath.sv
// Datapath of the modular inverse unit: Euclid registers, coefficient
// registers and a shared bit-serial restoring divider. Depends on mie_pkg.
module mie_dpath (
	input  logic                        clk,
	input  mie_pkg::dp_cmd_t            cmd,
	input  logic [mie_pkg::WIDTH-1:0]   value,
	input  logic [mie_pkg::WIDTH-1:0]   modulus,
	output mie_pkg::dp_stat_t           stat,
	output logic [mie_pkg::WIDTH-1:0]   inverse,
	output logic [mie_pkg::WIDTH-1:0]   gcd
);

	// remainder sequence, modulus and coefficients (sign and magnitude)
	logic [mie_pkg::WIDTH-1:0] pr_q, cr_q, m_q;
	logic [mie_pkg::DW-1:0]    pm_q, cm_q;
	logic                      pn_q, cn_q;
	// divider state
	logic [mie_pkg::WIDTH-1:0] rem_q, dvs_q;
	logic [mie_pkg::DW-1:0]    dq_q, prod_q;
	// result
	logic [mie_pkg::WIDTH-1:0] inv_q, gcd_q;

	logic [mie_pkg::WIDTH:0]   trial, diff;
	logic                      qbit;
	logic [mie_pkg::DW-1:0]    nmag;
	logic                      nneg, pneg;
	logic [mie_pkg::WIDTH-1:0] red;

	// one restoring division bit
	always_comb begin
		trial = {rem_q, dq_q[mie_pkg::DW-1]};
		diff  = trial - {1'b0, dvs_q};
		qbit  = (trial >= {1'b0, dvs_q});
	end

	// new coefficient = prev - q*cur, in sign and magnitude
	always_comb begin
		pneg = ~cn_q;
		priority if (prod_q == '0) begin
			nmag = pm_q;
			nneg = pn_q;
		end else if (pm_q == '0) begin
			nmag = prod_q;
			nneg = pneg;
		end else if (pn_q == pneg) begin
			nmag = pm_q + prod_q;
			nneg = pn_q;
		end else if (pm_q >= prod_q) begin
			nmag = pm_q - prod_q;
			nneg = pn_q;
		end else begin
			nmag = prod_q - pm_q;
			nneg = pneg;
		end
		if (nmag == '0) begin
			nneg = 1'b0;
		end
	end

	assign red = rem_q;

	// sequence and coefficient registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pr_q <= modulus;
			cr_q <= value;
			m_q  <= modulus;
			pm_q <= '0;
			pn_q <= 1'b0;
			cm_q <= mie_pkg::DW'(1);
			cn_q <= 1'b0;
		end else if (cmd.update) begin
			pr_q <= cr_q;
			cr_q <= rem_q;
			pm_q <= cm_q;
			pn_q <= cn_q;
			cm_q <= nmag;
			cn_q <= nneg;
		end
	end

	// shared divider: quotient bits shift into dq_q, q*cur accumulates in prod_q
	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q  <= '0;
			prod_q <= '0;
			if (cmd.reduce) begin
				dq_q  <= pm_q;
				dvs_q <= m_q;
			end else begin
				dq_q  <= {2'b00, pr_q};
				dvs_q <= cr_q;
			end
		end else if (cmd.div_step) begin
			rem_q  <= qbit ? diff[mie_pkg::WIDTH-1:0] : trial[mie_pkg::WIDTH-1:0];
			dq_q   <= {dq_q[mie_pkg::DW-2:0], qbit};
			prod_q <= {prod_q[mie_pkg::DW-2:0], 1'b0} + (qbit ? cm_q : '0);
		end
	end

	// reduce the coefficient into 0..modulus-1 and hold the result
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (m_q == '0) begin
				inv_q <= '0;
				gcd_q <= cr_q;
			end else begin
				inv_q <= (pn_q && red != '0) ? m_q - red : red;
				gcd_q <= pr_q;
			end
		end
	end

	assign stat.cur_zero = (cr_q == '0);
	assign stat.mod_zero = (m_q == '0);
	assign inverse       = inv_q;
	assign gcd           = gcd_q;

endmodule

FILE: rtl/core/mie_ctrl.sv
// Controller of the modular inverse unit: sequences Euclid steps and the
// final reduction on the shared divider. Depends on mie_pkg.
module mie_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  mie_pkg::dp_stat_t    stat,
	output mie_pkg::dp_cmd_t     cmd,
	output logic                 busy,
	output logic                 done
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CHECK  = 3'd1;
	localparam logic [2:0] S_DIV    = 3'd2;
	localparam logic [2:0] S_UPDATE = 3'd3;
	localparam logic [2:0] S_FINISH = 3'd4;

	logic [2:0]                   state_q, state_d;
	logic [mie_pkg::STEP_W-1:0]   step_q;
	logic [mie_pkg::DCNT_W-1:0]   dcnt_q;
	logic                         reduce_q, done_q;
	logic                         stop;

	assign stop = stat.cur_zero || (step_q == mie_pkg::STEP_W'(mie_pkg::STEP_LIMIT));

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = start;
				if (start) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.mod_zero) begin
					state_d = S_FINISH;
				end else begin
					cmd.div_init = 1'b1;
					cmd.reduce   = stop;
					state_d      = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (dcnt_q == mie_pkg::DCNT_W'(mie_pkg::DW - 1)) begin
					state_d = reduce_q ? S_FINISH : S_UPDATE;
				end
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = S_CHECK;
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state, counters and done strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			step_q   <= '0;
			dcnt_q   <= '0;
			reduce_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.finish;
			if (cmd.load) begin
				step_q <= '0;
			end else if (cmd.update) begin
				step_q <= step_q + 1'b1;
			end
			if (cmd.div_init) begin
				dcnt_q   <= '0;
				reduce_q <= cmd.reduce;
			end else if (cmd.div_step) begin
				dcnt_q <= dcnt_q + 1'b1;
			end
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

FILE: rtl/core/modular_inverse_ext_euclid_unit.sv
// Top level of the modular inverse unit (extended Euclid).
// Depends on mie_pkg, mie_ctrl and mie_dpath.
//
// Usage: drive value and modulus and raise start while busy is low; the word
// is taken at that clock edge and busy rises. When the work is over, done
// pulses for one cycle with inverse and gcd valid; they hold until the next
// result. inverse is the Bezout coefficient of value reduced into
// 0..modulus-1; it is the modular inverse only when gcd is one.
// A zero modulus gives inverse 0 and gcd equal to value.
// Each Euclid step is a setup, a pass of the bit-serial divider over all DW
// dividend bits and a commit; the final reduction is a setup, a divider
// pass and the result register. With k remainder steps (at most 45 for
// 31-bit operands) done pulses after k steps and the final reduction, all
// on the shared divider. A new word is accepted at the edge that ends the
// done cycle; while a word is in flight busy is high and no new word is
// taken. The receiver cannot stall: a result not taken in its strobe cycle
// is still held on the ports.
// Reset (arst_n low) returns the controller to idle at once; no result is
// produced for a word in flight.
module modular_inverse_ext_euclid_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [mie_pkg::WIDTH-1:0]   value,
	input  logic [mie_pkg::WIDTH-1:0]   modulus,
	output logic                        done,
	output logic [mie_pkg::WIDTH-1:0]   inverse,
	output logic [mie_pkg::WIDTH-1:0]   gcd
);

	mie_pkg::dp_cmd_t  cmd;
	mie_pkg::dp_stat_t stat;

	mie_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	mie_dpath u_dpath (
		.clk     (clk),
		.cmd     (cmd),
		.value   (value),
		.modulus (modulus),
		.stat    (stat),
		.inverse (inverse),
		.gcd     (gcd)
	);

endmodule

FILE: rtl/core/mie_checker.sv
// Port-level checker for the modular inverse unit, bound to the top level.
// Depends on the top level's port list only.
module mie_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// an accepted word makes the unit busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	// a result appears only once the unit is idle again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// the result strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// finishing a word always delivers its result
	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

endmodule

bind modular_inverse_ext_euclid_unit mie_checker u_mie_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);
